// File: design/pib_pkg.sv
// Shared types, constants and reset tables for the bridge configuration space.
package pib_pkg;

    localparam int REG_SPACE = 256;
    localparam int ADDR_W    = $clog2(REG_SPACE);

    // Access kinds and function numbers
    localparam logic       ACC_READ  = 1'b0;
    localparam logic       ACC_WRITE = 1'b1;
    localparam logic [2:0] FN_BRIDGE = 3'd0;
    localparam logic [2:0] FN_IDE    = 3'd1;

    // Configuration register indexes
    localparam int          CFG_IDX_W     = 2;
    localparam logic [1:0]  CFG_BRIDGE_ID = 2'd0;
    localparam logic [1:0]  CFG_IDE_ID    = 2'd1;
    localparam logic [15:0] BRIDGE_ID_RST = 16'h8886;
    localparam logic [15:0] IDE_FULL_ID   = 16'h673a;

    // PMU interrupt codes
    localparam logic [1:0] PMU_NONE  = 2'd0;
    localparam logic [1:0] PMU_IRQ10 = 2'd1;
    localparam logic [1:0] PMU_IRQ15 = 2'd2;

    localparam logic [1:0] CLK_RSVD   = 2'd3;
    localparam logic [4:0] ROUTE_OFF  = 5'd16;
    localparam logic [7:0] W1C_MASK07 = 8'hf9;
    localparam logic [7:0] SMI_BITS   = 8'hc0;
    localparam logic [7:0] READ_ABSENT = 8'hff;

    // Bridge byte offsets with special handling
    localparam logic [ADDR_W-1:0] BR_STATUS = 8'h07;
    localparam logic [ADDR_W-1:0] BR_PMSTS  = 8'ha2;
    localparam logic [ADDR_W-1:0] BR_SMI    = 8'ha3;
    localparam logic [ADDR_W-1:0] BR_PCICLK = 8'ha4;
    localparam logic [ADDR_W-1:0] BR_ISACLK = 8'h56;

    // IDE writable byte offsets
    localparam logic [ADDR_W-1:0] IDE_CMD    = 8'h04;
    localparam logic [ADDR_W-1:0] IDE_STATUS = 8'h07;
    localparam logic [ADDR_W-1:0] IDE_INTLN  = 8'h3c;
    localparam logic [ADDR_W-1:0] IDE_EXT_LO = 8'h40;
    localparam logic [ADDR_W-1:0] IDE_EXT_HI = 8'h59;
    localparam int                IDE_EXT_N  = 26;
    localparam int                IDE_EXT_W  = $clog2(IDE_EXT_N);

    typedef struct packed {
        logic              func;
        logic [2:0]        pci_function;
        logic [ADDR_W-1:0] reg_addr;
        logic [7:0]        write_data;
    } pib_in_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic [4:0] route_inta;
        logic [4:0] route_intb;
        logic [4:0] route_intc;
        logic [4:0] route_intd;
        logic [3:0] level_mask;
        logic       smi_pulse;
        logic [1:0] pmu_irq;
        logic [1:0] pci_clock_code;
        logic [1:0] isa_divider_code;
        logic       ide_primary_on;
        logic       ide_secondary_on;
    } pib_out_t;

    // Byte write request into a register file
    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        data;
    } pib_wreq_t;

    // Bridge-derived status after the access
    typedef struct packed {
        logic [4:0] route_inta;
        logic [4:0] route_intb;
        logic [4:0] route_intc;
        logic [4:0] route_intd;
        logic [3:0] level_mask;
        logic       smi;
        logic [1:0] pmu;
        logic [1:0] pci_code;
        logic [1:0] isa_code;
    } pib_bstat_t;

    // Read-only bridge bytes
    function automatic logic [7:0] bridge_const(input logic [ADDR_W-1:0] addr,
                                                input logic [15:0] dev_id);
        logic [7:0] v;
        v = 8'h00;
        case (addr)
            8'h00:   v = 8'h60;
            8'h01:   v = 8'h10;
            8'h02:   v = dev_id[7:0];
            8'h03:   v = dev_id[15:8];
            8'h08:   v = 8'h0e;
            8'h0a:   v = 8'h01;
            8'h0b:   v = 8'h06;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

    // IDE identity table for a given strap id
    function automatic logic [7:0] ide_const(input logic [15:0] id,
                                             input logic [ADDR_W-1:0] addr);
        logic [7:0] v;
        logic       full;
        v    = 8'h00;
        full = (id == IDE_FULL_ID);
        case (addr)
            8'h00:   v = 8'h60;
            8'h01:   v = 8'h10;
            8'h02:   v = id[7:0];
            8'h03:   v = id[15:8];
            8'h04:   v = 8'h05;
            8'h08:   v = 8'h10;
            8'h09:   v = 8'h8f;
            8'h0a:   v = 8'h01;
            8'h0b:   v = 8'h01;
            8'h10:   v = 8'hf1;
            8'h11:   v = 8'h01;
            8'h14:   v = 8'hf5;
            8'h15:   v = 8'h03;
            8'h18:   v = 8'h71;
            8'h19:   v = 8'h01;
            8'h1c:   v = 8'h75;
            8'h1d:   v = 8'h03;
            8'h20:   v = 8'h01;
            8'h21:   v = 8'h10;
            8'h41:   v = full ? 8'hc0 : 8'h00;
            8'h48, 8'h49, 8'h4a, 8'h4b: v = full ? 8'h55 : 8'h00;
            8'h4c, 8'h4d:               v = full ? 8'h88 : 8'h00;
            8'h4e, 8'h4f:               v = full ? 8'haa : 8'h00;
            default: v = 8'h00;
        endcase
        if (id == 16'h0000)
        begin
            v = 8'h00;
        end
        return v;
    endfunction

endpackage

// File: design/pci_isa_bridge_config_space.sv
// Top level: request and result registers, configuration straps, register files.
//
//  channel | signals                         | direction | payload
//  --------+---------------------------------+-----------+----------------------------
//  in      | in_valid / in_ready / in_data   | into blk  | pib_in_t (one byte access)
//  out     | out_valid / out_ready / out_data| out of blk| pib_out_t (read byte, status)
//  cfg     | cfg_valid / cfg_ready           | into blk  | cfg_index, cfg_data (16 bits)
//
// One request per cycle sustained while out_ready stays high; a request passes
// the request register, then the result register, whose value is formed by the
// single pass through the register files.
// Reset loads the bridge reset table and clears the IDE function (no IDE).
// A stalled result holds; the request register still drains into it on the
// cycle out_ready is seen. Configuration writes are never stalled (cfg_ready is high).
module pci_isa_bridge_config_space (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  pib_pkg::pib_in_t                    in_data,
    output logic                                out_valid,
    input  logic                                out_ready,
    output pib_pkg::pib_out_t                   out_data,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [pib_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [15:0]                         cfg_data
);

    logic [15:0]         bridge_id_reg;
    logic [15:0]         ide_id_reg;
    logic                req_vld_reg;
    pib_pkg::pib_in_t    req_reg;
    logic                res_vld_reg;
    logic                res_vld_next;
    pib_pkg::pib_out_t   res_reg;
    pib_pkg::pib_out_t   res_next;

    logic                adv;
    logic                is_wr;
    logic                full_ide;
    logic                ide_load;
    pib_pkg::pib_wreq_t  br_wreq;
    pib_pkg::pib_wreq_t  ide_wreq;
    pib_pkg::pib_bstat_t br_stat;
    logic [7:0]          br_rd;
    logic [7:0]          ide_rd;
    logic                prim_on;
    logic                sec_on;

    // Handshake
    assign adv       = req_vld_reg && (!res_vld_reg || out_ready);
    assign in_ready  = !req_vld_reg || adv;
    assign out_valid = res_vld_reg;
    assign out_data  = res_reg;
    assign cfg_ready = 1'b1;

    assign is_wr    = (req_reg.func == pib_pkg::ACC_WRITE);
    assign full_ide = (ide_id_reg == pib_pkg::IDE_FULL_ID);
    assign ide_load = cfg_valid && (cfg_index == pib_pkg::CFG_IDE_ID);

    // Write requests to the two functions
    always_comb
    begin
        br_wreq.we    = adv && is_wr && (req_reg.pci_function == pib_pkg::FN_BRIDGE);
        br_wreq.addr  = req_reg.reg_addr;
        br_wreq.data  = req_reg.write_data;
        ide_wreq.we   = adv && is_wr && full_ide &&
                        (req_reg.pci_function == pib_pkg::FN_IDE);
        ide_wreq.addr = req_reg.reg_addr;
        ide_wreq.data = req_reg.write_data;
    end

    pib_bridge_regs u_bridge (
        .clk     (clk),
        .rst_n   (rst_n),
        .wreq    (br_wreq),
        .dev_id  (bridge_id_reg),
        .rd_data (br_rd),
        .stat    (br_stat)
    );

    pib_ide_regs u_ide (
        .clk     (clk),
        .rst_n   (rst_n),
        .load    (ide_load),
        .load_id (cfg_data),
        .id      (ide_id_reg),
        .wreq    (ide_wreq),
        .rd_data (ide_rd),
        .prim_on (prim_on),
        .sec_on  (sec_on)
    );

    // Result assembly
    always_comb
    begin
        res_next.read_data = 8'h00;
        if (!is_wr)
        begin
            if (req_reg.pci_function == pib_pkg::FN_BRIDGE)
                res_next.read_data = br_rd;
            else if (req_reg.pci_function == pib_pkg::FN_IDE && full_ide)
                res_next.read_data = ide_rd;
            else
                res_next.read_data = pib_pkg::READ_ABSENT;
        end
        res_next.route_inta       = br_stat.route_inta;
        res_next.route_intb       = br_stat.route_intb;
        res_next.route_intc       = br_stat.route_intc;
        res_next.route_intd       = br_stat.route_intd;
        res_next.level_mask       = br_stat.level_mask;
        res_next.smi_pulse        = br_stat.smi;
        res_next.pmu_irq          = br_stat.pmu;
        res_next.pci_clock_code   = br_stat.pci_code;
        res_next.isa_divider_code = br_stat.isa_code;
        res_next.ide_primary_on   = prim_on;
        res_next.ide_secondary_on = sec_on;
    end

    assign res_vld_next = adv || (res_vld_reg && !out_ready);

    // Control and strap registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bridge_id_reg <= pib_pkg::BRIDGE_ID_RST;
            ide_id_reg    <= '0;
            req_vld_reg   <= 1'b0;
            res_vld_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_index == pib_pkg::CFG_BRIDGE_ID)
                bridge_id_reg <= cfg_data;
            if (ide_load)
                ide_id_reg <= cfg_data;
            if (in_ready)
                req_vld_reg <= in_valid;
            res_vld_reg <= res_vld_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            req_reg <= in_data;
        if (adv)
            res_reg <= res_next;
    end

endmodule

// File: design/pib_bridge_regs.sv
// Function 0 register file: writable bytes, SMI trigger, held clock codes.
module pib_bridge_regs (
    input  logic                       clk,
    input  logic                       rst_n,
    input  pib_pkg::pib_wreq_t         wreq,
    input  logic [15:0]                dev_id,
    output logic [7:0]                 rd_data,
    output pib_pkg::pib_bstat_t        stat
);

    logic [7:0] cmd_reg [0:1];
    logic [7:0] cmd_next[0:1];
    logic [7:0] sts_reg;
    logic [7:0] sts_next;
    logic [7:0] lat_reg [0:1];
    logic [7:0] lat_next[0:1];
    logic [7:0] g4_reg  [0:7];
    logic [7:0] g4_next [0:7];
    logic [7:0] g5_reg  [0:7];
    logic [7:0] g5_next [0:7];
    logic [7:0] g7_reg  [0:6];
    logic [7:0] g7_next [0:6];
    logic [7:0] g8_reg  [0:3];
    logic [7:0] g8_next [0:3];
    logic [7:0] g9_reg  [0:2];
    logic [7:0] g9_next [0:2];
    logic [7:0] ga_reg  [0:8];
    logic [7:0] ga_next [0:8];
    logic [1:0] held_pci_reg;
    logic [1:0] held_pci_next;
    logic [1:0] held_isa_reg;
    logic [1:0] held_isa_next;

    logic [3:0] lo;
    logic       smi;
    logic [1:0] pmu;

    assign lo = wreq.addr[3:0];

    // Read path: stored bytes before the access, constants elsewhere
    always_comb
    begin
        rd_data = pib_pkg::bridge_const(wreq.addr, dev_id);
        case (wreq.addr[7:4])
            4'h0:
            begin
                if (lo == 4'h4 || lo == 4'h5)
                    rd_data = cmd_reg[lo[0]];
                else if (lo == 4'h7)
                    rd_data = sts_reg;
                else if (lo == 4'hc || lo == 4'hd)
                    rd_data = lat_reg[lo[0]];
            end
            4'h4:
            begin
                if (!lo[3])
                    rd_data = g4_reg[lo[2:0]];
            end
            4'h5:
            begin
                if (!lo[3])
                    rd_data = g5_reg[lo[2:0]];
            end
            4'h7:
            begin
                if (lo <= 4'h6)
                    rd_data = g7_reg[lo[2:0]];
            end
            4'h8:
            begin
                if (lo <= 4'h3)
                    rd_data = g8_reg[lo[1:0]];
            end
            4'h9:
            begin
                if (lo <= 4'h2)
                    rd_data = g9_reg[lo[1:0]];
            end
            4'ha:
            begin
                if (lo <= 4'h8)
                    rd_data = ga_reg[lo];
            end
            default: ;
        endcase
    end

    // Write decode per register rules
    always_comb
    begin
        cmd_next = cmd_reg;
        sts_next = sts_reg;
        lat_next = lat_reg;
        g4_next  = g4_reg;
        g5_next  = g5_reg;
        g7_next  = g7_reg;
        g8_next  = g8_reg;
        g9_next  = g9_reg;
        ga_next  = ga_reg;
        if (wreq.we)
        begin
            case (wreq.addr[7:4])
                4'h0:
                begin
                    if (lo == 4'h4 || lo == 4'h5)
                        cmd_next[lo[0]] = wreq.data;
                    else if (lo == 4'h7)
                        sts_next = sts_reg & ~(wreq.data & pib_pkg::W1C_MASK07);
                    else if (lo == 4'hc || lo == 4'hd)
                        lat_next[lo[0]] = wreq.data;
                end
                4'h4:
                begin
                    if (!lo[3])
                        g4_next[lo[2:0]] = wreq.data;
                end
                4'h5:
                begin
                    if (!lo[3])
                        g5_next[lo[2:0]] = wreq.data;
                end
                4'h7:
                begin
                    if (lo <= 4'h6)
                        g7_next[lo[2:0]] = wreq.data;
                end
                4'h8:
                begin
                    if (lo <= 4'h3)
                        g8_next[lo[1:0]] = wreq.data;
                end
                4'h9:
                begin
                    if (lo <= 4'h2)
                        g9_next[lo[1:0]] = wreq.data;
                end
                4'ha:
                begin
                    if (wreq.addr == pib_pkg::BR_PMSTS)
                        ga_next[lo] = ga_reg[lo] & ~wreq.data;
                    else if (lo <= 4'h8)
                        ga_next[lo] = wreq.data;
                end
                default: ;
            endcase
        end
    end

    // Software SMI or PMU interrupt: rising request on bits 7:6 against the stored bit 6
    always_comb
    begin
        smi = 1'b0;
        pmu = pib_pkg::PMU_NONE;
        if (wreq.we && wreq.addr == pib_pkg::BR_SMI &&
            (wreq.data & pib_pkg::SMI_BITS) == pib_pkg::SMI_BITS && !ga_reg[3][6])
        begin
            if (g4_reg[6][6])
                pmu = g4_reg[6][7] ? pib_pkg::PMU_IRQ15 : pib_pkg::PMU_IRQ10;
            else
                smi = 1'b1;
        end
    end

    // Held clock codes: reserved code keeps the old one
    always_comb
    begin
        held_pci_next = held_pci_reg;
        held_isa_next = held_isa_reg;
        if (wreq.we && (wreq.addr == pib_pkg::BR_PCICLK || wreq.addr == pib_pkg::BR_ISACLK))
        begin
            if (ga_next[4][1:0] != pib_pkg::CLK_RSVD)
                held_pci_next = ga_next[4][1:0];
            if (g5_next[6][1:0] != pib_pkg::CLK_RSVD)
                held_isa_next = g5_next[6][1:0];
        end
    end

    // Status seen after the access
    always_comb
    begin
        stat.route_inta = g4_next[6][0] ? {1'b0, g4_next[3][7:4]} : pib_pkg::ROUTE_OFF;
        stat.route_intb = g4_next[6][1] ? {1'b0, g4_next[3][3:0]} : pib_pkg::ROUTE_OFF;
        stat.route_intc = g4_next[6][2] ? {1'b0, g4_next[4][7:4]} : pib_pkg::ROUTE_OFF;
        stat.route_intd = g4_next[6][3] ? {1'b0, g4_next[4][3:0]} : pib_pkg::ROUTE_OFF;
        stat.level_mask = g4_next[7][3:0];
        stat.smi        = smi;
        stat.pmu        = pmu;
        stat.pci_code   = held_pci_next;
        stat.isa_code   = held_isa_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_reg[0]   <= 8'h0f;
            cmd_reg[1]   <= '0;
            sts_reg      <= 8'h02;
            lat_reg[0]   <= '0;
            lat_reg[1]   <= '0;
            g4_reg[0]    <= 8'h01;
            g4_reg[1]    <= 8'h04;
            g4_reg[2]    <= 8'h08;
            g4_reg[3]    <= 8'h9a;
            g4_reg[4]    <= 8'hbc;
            g4_reg[5]    <= '0;
            g4_reg[6]    <= 8'h10;
            g4_reg[7]    <= 8'h30;
            g5_reg[0]    <= '0;
            g5_reg[1]    <= 8'h02;
            for (int i = 2; i < 8; i++)
                g5_reg[i] <= '0;
            for (int i = 0; i < 7; i++)
                g7_reg[i] <= '0;
            for (int i = 0; i < 4; i++)
                g8_reg[i] <= '0;
            for (int i = 0; i < 3; i++)
                g9_reg[i] <= '0;
            for (int i = 0; i < 9; i++)
                ga_reg[i] <= '0;
            held_pci_reg <= '0;
            held_isa_reg <= '0;
        end
        else
        begin
            cmd_reg      <= cmd_next;
            sts_reg      <= sts_next;
            lat_reg      <= lat_next;
            g4_reg       <= g4_next;
            g5_reg       <= g5_next;
            g7_reg       <= g7_next;
            g8_reg       <= g8_next;
            g9_reg       <= g9_next;
            ga_reg       <= ga_next;
            held_pci_reg <= held_pci_next;
            held_isa_reg <= held_isa_next;
        end
    end

endmodule

// File: design/pib_ide_regs.sv
// Function 1 (IDE) register file: writable bytes, strap reload, channel enables.
module pib_ide_regs (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  logic [15:0]         load_id,
    input  logic [15:0]         id,
    input  pib_pkg::pib_wreq_t  wreq,
    output logic [7:0]          rd_data,
    output logic                prim_on,
    output logic                sec_on
);

    logic [7:0] cmd_reg;
    logic [7:0] cmd_next;
    logic [7:0] sts_reg;
    logic [7:0] sts_next;
    logic [7:0] intln_reg;
    logic [7:0] intln_next;
    logic [7:0] ext_reg [0:pib_pkg::IDE_EXT_N-1];
    logic [7:0] ext_next[0:pib_pkg::IDE_EXT_N-1];

    logic [pib_pkg::ADDR_W-1:0] off;
    logic                       in_ext;
    logic                       full;

    assign off    = wreq.addr - pib_pkg::IDE_EXT_LO;
    assign in_ext = (wreq.addr >= pib_pkg::IDE_EXT_LO) && (wreq.addr <= pib_pkg::IDE_EXT_HI);
    assign full   = (id == pib_pkg::IDE_FULL_ID);

    // Read path
    always_comb
    begin
        rd_data = pib_pkg::ide_const(id, wreq.addr);
        if (wreq.addr == pib_pkg::IDE_CMD)
            rd_data = cmd_reg;
        else if (wreq.addr == pib_pkg::IDE_STATUS)
            rd_data = sts_reg;
        else if (wreq.addr == pib_pkg::IDE_INTLN)
            rd_data = intln_reg;
        else if (in_ext)
            rd_data = ext_reg[off[pib_pkg::IDE_EXT_W-1:0]];
    end

    // Strap reload or byte write
    always_comb
    begin
        cmd_next   = cmd_reg;
        sts_next   = sts_reg;
        intln_next = intln_reg;
        ext_next   = ext_reg;
        if (load)
        begin
            cmd_next   = pib_pkg::ide_const(load_id, pib_pkg::IDE_CMD);
            sts_next   = pib_pkg::ide_const(load_id, pib_pkg::IDE_STATUS);
            intln_next = pib_pkg::ide_const(load_id, pib_pkg::IDE_INTLN);
            for (int k = 0; k < pib_pkg::IDE_EXT_N; k++)
                ext_next[k] = pib_pkg::ide_const(load_id,
                    pib_pkg::IDE_EXT_LO + pib_pkg::ADDR_W'(k));
        end
        else if (wreq.we)
        begin
            if (wreq.addr == pib_pkg::IDE_STATUS)
                sts_next = sts_reg & ~(wreq.data & pib_pkg::W1C_MASK07);
            else if (wreq.addr == pib_pkg::IDE_CMD)
                cmd_next = wreq.data;
            else if (wreq.addr == pib_pkg::IDE_INTLN)
                intln_next = wreq.data;
            else if (in_ext)
                ext_next[off[pib_pkg::IDE_EXT_W-1:0]] = wreq.data;
        end
    end

    // Channel enables after the access (byte 0x41 is ext entry 1)
    assign prim_on = full && cmd_next[0] && ext_next[1][7];
    assign sec_on  = full && cmd_next[0] && ext_next[1][6];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_reg   <= '0;
            sts_reg   <= '0;
            intln_reg <= '0;
            for (int k = 0; k < pib_pkg::IDE_EXT_N; k++)
                ext_reg[k] <= '0;
        end
        else
        begin
            cmd_reg   <= cmd_next;
            sts_reg   <= sts_next;
            intln_reg <= intln_next;
            ext_reg   <= ext_next;
        end
    end

endmodule

// File: verif/pci_isa_bridge_config_space_test.sv
// Self-checking testbench for the PCI-to-ISA bridge configuration space block.
module pci_isa_bridge_config_space_test;
    timeunit 1ns;
    timeprecision 1ps;

    // Bridge bytes that feed the status outputs
    localparam logic [7:0] BR_ROUTE_AB = 8'h43;
    localparam logic [7:0] BR_ROUTE_CD = 8'h44;
    localparam logic [7:0] BR_INT_EN   = 8'h46;
    localparam logic [7:0] BR_LEVEL    = 8'h47;
    localparam logic [7:0] IDE_CHAN_EN = 8'h41;

    // Bytes with special rules, picked more often by the random requests
    localparam logic [7:0] HOT_BYTES [20] = '{8'h02, 8'h03, 8'h04, 8'h07, 8'h3c, 8'h40,
        8'h41, 8'h43, 8'h44, 8'h46, 8'h47, 8'h4c, 8'h56, 8'h59, 8'h5a, 8'ha2, 8'ha3,
        8'ha4, 8'ha8, 8'ha9};

    // Expected status of every accepted request, plus a copy of both register files
    class bridge_space_board_t;
        logic [7:0]  bridge_bytes [256];
        logic [7:0]  ide_bytes [256];
        logic [15:0] bridge_id;
        logic [15:0] ide_id;
        logic [1:0]  pci_hold;
        logic [1:0]  isa_hold;
        pib_pkg::pib_out_t expected_status [$];
        int          mismatches;

        function new();
            mismatches = 0;
            power_on();
        endfunction

        function void load_ide_table();
            foreach (ide_bytes[i])
                ide_bytes[i] = 8'h00;
            if (ide_id != 16'h0000)
            begin
                ide_bytes[8'h00] = 8'h60; ide_bytes[8'h01] = 8'h10;
                ide_bytes[8'h02] = ide_id[7:0]; ide_bytes[8'h03] = ide_id[15:8];
                ide_bytes[8'h04] = 8'h05; ide_bytes[8'h08] = 8'h10;
                ide_bytes[8'h09] = 8'h8f; ide_bytes[8'h0a] = 8'h01;
                ide_bytes[8'h0b] = 8'h01;
                ide_bytes[8'h10] = 8'hf1; ide_bytes[8'h11] = 8'h01;
                ide_bytes[8'h14] = 8'hf5; ide_bytes[8'h15] = 8'h03;
                ide_bytes[8'h18] = 8'h71; ide_bytes[8'h19] = 8'h01;
                ide_bytes[8'h1c] = 8'h75; ide_bytes[8'h1d] = 8'h03;
                ide_bytes[8'h20] = 8'h01; ide_bytes[8'h21] = 8'h10;
                if (ide_id == pib_pkg::IDE_FULL_ID)
                begin
                    ide_bytes[8'h41] = 8'hc0;
                    for (int i = 8'h48; i <= 8'h4b; i++)
                        ide_bytes[i] = 8'h55;
                    ide_bytes[8'h4c] = 8'h88; ide_bytes[8'h4d] = 8'h88;
                    ide_bytes[8'h4e] = 8'haa; ide_bytes[8'h4f] = 8'haa;
                end
            end
        endfunction

        // Reserved code 3 keeps the previously applied ratio
        function void retime();
            if (bridge_bytes[pib_pkg::BR_PCICLK][1:0] != pib_pkg::CLK_RSVD)
                pci_hold = bridge_bytes[pib_pkg::BR_PCICLK][1:0];
            if (bridge_bytes[pib_pkg::BR_ISACLK][1:0] != pib_pkg::CLK_RSVD)
                isa_hold = bridge_bytes[pib_pkg::BR_ISACLK][1:0];
        endfunction

        function void power_on();
            bridge_id = pib_pkg::BRIDGE_ID_RST;
            ide_id    = 16'h0000;
            foreach (bridge_bytes[i])
                bridge_bytes[i] = 8'h00;
            bridge_bytes[8'h00] = 8'h60; bridge_bytes[8'h01] = 8'h10;
            bridge_bytes[8'h02] = bridge_id[7:0]; bridge_bytes[8'h03] = bridge_id[15:8];
            bridge_bytes[8'h04] = 8'h0f; bridge_bytes[8'h07] = 8'h02;
            bridge_bytes[8'h08] = 8'h0e; bridge_bytes[8'h0a] = 8'h01;
            bridge_bytes[8'h0b] = 8'h06;
            bridge_bytes[8'h40] = 8'h01; bridge_bytes[8'h41] = 8'h04;
            bridge_bytes[8'h42] = 8'h08;
            bridge_bytes[BR_ROUTE_AB] = 8'h9a; bridge_bytes[BR_ROUTE_CD] = 8'hbc;
            bridge_bytes[BR_INT_EN] = 8'h10; bridge_bytes[BR_LEVEL] = 8'h30;
            bridge_bytes[8'h51] = 8'h02;
            load_ide_table();
            pci_hold = 2'd0;
            isa_hold = 2'd0;
            retime();
        endfunction

        function void apply_strap(logic [1:0] idx, logic [15:0] value);
            if (idx == pib_pkg::CFG_BRIDGE_ID)
            begin
                bridge_id = value;
                bridge_bytes[8'h02] = value[7:0];
                bridge_bytes[8'h03] = value[15:8];
            end
            else if (idx == pib_pkg::CFG_IDE_ID)
            begin
                ide_id = value;
                load_ide_table();
            end
        endfunction

        function bit bridge_writable(logic [7:0] a);
            return (a >= 8'h04 && a <= 8'h05) || (a >= 8'h0c && a <= 8'h0d) ||
                   (a >= 8'h40 && a <= 8'h47) || (a >= 8'h50 && a <= 8'h57) ||
                   (a >= 8'h70 && a <= 8'h76) || (a >= 8'h80 && a <= 8'h83) ||
                   (a >= 8'h90 && a <= 8'h92) || (a >= 8'ha0 && a <= 8'ha1) ||
                   (a >= 8'ha4 && a <= 8'ha8);
        endfunction

        function logic [4:0] route(logic en, logic [3:0] irq);
            return en ? {1'b0, irq} : pib_pkg::ROUTE_OFF;
        endfunction

        // Apply one access and queue the status it must produce
        function void note_request(pib_pkg::pib_in_t req);
            logic [7:0] a;
            logic [7:0] d;
            logic       full;
            logic       ide_on;
            pib_pkg::pib_out_t st;
            a    = req.reg_addr;
            d    = req.write_data;
            full = (ide_id == pib_pkg::IDE_FULL_ID);
            st   = '0;
            st.smi_pulse = 1'b0;
            st.pmu_irq   = pib_pkg::PMU_NONE;
            if (req.func == pib_pkg::ACC_READ)
            begin
                if (req.pci_function == pib_pkg::FN_BRIDGE)
                    st.read_data = bridge_bytes[a];
                else if (req.pci_function == pib_pkg::FN_IDE && full)
                    st.read_data = ide_bytes[a];
                else
                    st.read_data = pib_pkg::READ_ABSENT;
            end
            else if (req.pci_function == pib_pkg::FN_BRIDGE)
            begin
                if (a == pib_pkg::BR_STATUS)
                    bridge_bytes[a] &= ~(d & pib_pkg::W1C_MASK07);
                else if (a == pib_pkg::BR_PMSTS)
                    bridge_bytes[a] &= ~d;
                else if (a == pib_pkg::BR_SMI)
                begin
                    // Trigger only on a rising software SMI bit
                    if ((d & pib_pkg::SMI_BITS) == pib_pkg::SMI_BITS &&
                        !bridge_bytes[pib_pkg::BR_SMI][6])
                    begin
                        if (bridge_bytes[BR_INT_EN][6])
                            st.pmu_irq = bridge_bytes[BR_INT_EN][7] ? pib_pkg::PMU_IRQ15
                                                                     : pib_pkg::PMU_IRQ10;
                        else
                            st.smi_pulse = 1'b1;
                    end
                    bridge_bytes[a] = d;
                end
                else if (bridge_writable(a))
                begin
                    bridge_bytes[a] = d;
                    if (a == pib_pkg::BR_PCICLK || a == pib_pkg::BR_ISACLK)
                        retime();
                end
            end
            else if (req.pci_function == pib_pkg::FN_IDE && full)
            begin
                if (a == pib_pkg::IDE_STATUS)
                    ide_bytes[a] &= ~(d & pib_pkg::W1C_MASK07);
                else if (a == pib_pkg::IDE_CMD || a == pib_pkg::IDE_INTLN ||
                         (a >= pib_pkg::IDE_EXT_LO && a <= pib_pkg::IDE_EXT_HI))
                    ide_bytes[a] = d;
            end

            st.route_inta = route(bridge_bytes[BR_INT_EN][0], bridge_bytes[BR_ROUTE_AB][7:4]);
            st.route_intb = route(bridge_bytes[BR_INT_EN][1], bridge_bytes[BR_ROUTE_AB][3:0]);
            st.route_intc = route(bridge_bytes[BR_INT_EN][2], bridge_bytes[BR_ROUTE_CD][7:4]);
            st.route_intd = route(bridge_bytes[BR_INT_EN][3], bridge_bytes[BR_ROUTE_CD][3:0]);
            st.level_mask       = bridge_bytes[BR_LEVEL][3:0];
            st.pci_clock_code   = pci_hold;
            st.isa_divider_code = isa_hold;
            ide_on = full && ide_bytes[pib_pkg::IDE_CMD][0];
            st.ide_primary_on   = ide_on && ide_bytes[IDE_CHAN_EN][7];
            st.ide_secondary_on = ide_on && ide_bytes[IDE_CHAN_EN][6];
            expected_status.push_back(st);
        endfunction

        function void compare(string name, logic [7:0] want, logic [7:0] got);
            if (got !== want)
            begin
                $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
                mismatches++;
            end
        endfunction

        function void check_result(pib_pkg::pib_out_t got);
            pib_pkg::pib_out_t want;
            if (expected_status.size() == 0)
            begin
                $error("status returned with no request outstanding");
                mismatches++;
                return;
            end
            want = expected_status.pop_front();
            compare("read_data", want.read_data, got.read_data);
            compare("route_inta", 8'(want.route_inta), 8'(got.route_inta));
            compare("route_intb", 8'(want.route_intb), 8'(got.route_intb));
            compare("route_intc", 8'(want.route_intc), 8'(got.route_intc));
            compare("route_intd", 8'(want.route_intd), 8'(got.route_intd));
            compare("level_mask", 8'(want.level_mask), 8'(got.level_mask));
            compare("smi_pulse", 8'(want.smi_pulse), 8'(got.smi_pulse));
            compare("pmu_irq", 8'(want.pmu_irq), 8'(got.pmu_irq));
            compare("pci_clock_code", 8'(want.pci_clock_code), 8'(got.pci_clock_code));
            compare("isa_divider_code", 8'(want.isa_divider_code),
                    8'(got.isa_divider_code));
            compare("ide_primary_on", 8'(want.ide_primary_on), 8'(got.ide_primary_on));
            compare("ide_secondary_on", 8'(want.ide_secondary_on),
                    8'(got.ide_secondary_on));
        endfunction
    endclass

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_ready;
    pib_pkg::pib_in_t  in_data = '0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    pib_pkg::pib_out_t out_data;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [pib_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [15:0]       cfg_data = '0;

    bridge_space_board_t board = new();
    int gap_pct   = 0;
    int stall_pct = 0;
    int stall_left = 0;

    pci_isa_bridge_config_space dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #6 clk = ~clk;

    // Result side back-pressure: mostly short stalls, a few long ones
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left--;
            out_ready <= 1'b0;
        end
        else if ($urandom_range(99) < stall_pct)
        begin
            stall_left = ($urandom_range(9) == 0) ? int'($urandom_range(30, 8))
                                                  : int'($urandom_range(2, 0));
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= 1'b1;
        end
    end

    // Check every status taken by the receiver
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            board.check_result(out_data);
    end

    task automatic request_gap();
        int len;
        if ($urandom_range(99) < gap_pct)
        begin
            len = ($urandom_range(9) == 0) ? int'($urandom_range(30, 6))
                                           : int'($urandom_range(3, 1));
            in_valid <= 1'b0;
            repeat (len) @(posedge clk);
        end
    endtask

    // Present one request and hold it until taken
    task automatic issue(logic func, logic [2:0] fn, logic [7:0] a, logic [7:0] d);
        pib_pkg::pib_in_t req;
        req.func         = func;
        req.pci_function = fn;
        req.reg_addr     = a;
        req.write_data   = d;
        request_gap();
        in_data  <= req;
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        board.note_request(req);
    endtask

    task automatic random_access();
        logic       func;
        logic [2:0] fn;
        logic [7:0] a;
        logic [7:0] d;
        int         pick;
        func = 1'($urandom_range(1, 0));
        pick = int'($urandom_range(99));
        if (pick < 50)
            fn = pib_pkg::FN_BRIDGE;
        else if (pick < 85)
            fn = pib_pkg::FN_IDE;
        else
            fn = 3'($urandom_range(7, 0));
        a = ($urandom_range(99) < 65) ? HOT_BYTES[$urandom_range(19, 0)]
                                      : 8'($urandom_range(255, 0));
        d = 8'($urandom_range(255, 0));
        // Arm and fire the software SMI bits often enough to see every outcome
        if (a == pib_pkg::BR_SMI)
        begin
            case ($urandom_range(2))
                0: d = d | pib_pkg::SMI_BITS;
                1: d = d & ~pib_pkg::SMI_BITS;
                default: ;
            endcase
        end
        issue(func, fn, a, d);
    endtask

    task automatic write_strap(logic [1:0] idx, logic [15:0] value);
        cfg_index <= idx;
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        board.apply_strap(idx, value);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Stop sending and let every outstanding status come back
    task automatic settle();
        in_valid <= 1'b0;
        while (board.expected_status.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic random_run(int count, int gaps, int stalls);
        gap_pct   = gaps;
        stall_pct = stalls;
        repeat (count) random_access();
        settle();
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Bridge only, reset straps
        gap_pct   = 30;
        stall_pct = 30;
        issue(pib_pkg::ACC_READ, pib_pkg::FN_BRIDGE, 8'h00, 8'h00);
        issue(pib_pkg::ACC_READ, pib_pkg::FN_BRIDGE, 8'h02, 8'h00);
        issue(pib_pkg::ACC_READ, pib_pkg::FN_BRIDGE, 8'h03, 8'h00);
        issue(pib_pkg::ACC_WRITE, pib_pkg::FN_BRIDGE, pib_pkg::BR_STATUS, 8'hff);
        issue(pib_pkg::ACC_READ, pib_pkg::FN_BRIDGE, pib_pkg::BR_STATUS, 8'h00);
        issue(pib_pkg::ACC_WRITE, pib_pkg::FN_BRIDGE, pib_pkg::BR_PMSTS, 8'hff);
        issue(pib_pkg::ACC_WRITE, pib_pkg::FN_BRIDGE, pib_pkg::BR_SMI, 8'hc0);
        issue(pib_pkg::ACC_WRITE, pib_pkg::FN_BRIDGE, pib_pkg::BR_SMI, 8'hc0);
        issue(pib_pkg::ACC_WRITE, pib_pkg::FN_BRIDGE, pib_pkg::BR_SMI, 8'h00);
        issue(pib_pkg::ACC_WRITE, pib_pkg::FN_BRIDGE, BR_INT_EN, 8'h4f);
        issue(pib_pkg::ACC_WRITE, pib_pkg::FN_BRIDGE, pib_pkg::BR_SMI, 8'hc0);
        issue(pib_pkg::ACC_WRITE, pib_pkg::FN_BRIDGE, pib_pkg::BR_SMI, 8'h3f);
        issue(pib_pkg::ACC_WRITE, pib_pkg::FN_BRIDGE, BR_INT_EN, 8'hcf);
        issue(pib_pkg::ACC_WRITE, pib_pkg::FN_BRIDGE, pib_pkg::BR_SMI, 8'hff);
        issue(pib_pkg::ACC_WRITE, pib_pkg::FN_BRIDGE, pib_pkg::BR_PCICLK, 8'h02);
        issue(pib_pkg::ACC_WRITE, pib_pkg::FN_BRIDGE, pib_pkg::BR_ISACLK, 8'h01);
        issue(pib_pkg::ACC_WRITE, pib_pkg::FN_BRIDGE, pib_pkg::BR_PCICLK, 8'hff);
        issue(pib_pkg::ACC_WRITE, pib_pkg::FN_BRIDGE, pib_pkg::BR_ISACLK, 8'h03);
        issue(pib_pkg::ACC_WRITE, pib_pkg::FN_BRIDGE, BR_ROUTE_AB, 8'hff);
        issue(pib_pkg::ACC_WRITE, pib_pkg::FN_BRIDGE, BR_LEVEL, 8'hff);
        issue(pib_pkg::ACC_WRITE, pib_pkg::FN_BRIDGE, BR_INT_EN, 8'h00);
        issue(pib_pkg::ACC_READ, pib_pkg::FN_IDE, 8'h00, 8'h00);
        issue(pib_pkg::ACC_READ, 3'd7, 8'hff, 8'h00);
        issue(pib_pkg::ACC_WRITE, pib_pkg::FN_BRIDGE, 8'h00, 8'h12);
        issue(pib_pkg::ACC_READ, pib_pkg::FN_BRIDGE, 8'h00, 8'h00);
        settle();
        random_run(150, 30, 30);

        // Full IDE function present, bridge id at its top value
        write_strap(pib_pkg::CFG_BRIDGE_ID, 16'hffff);
        write_strap(pib_pkg::CFG_IDE_ID, pib_pkg::IDE_FULL_ID);
        gap_pct   = 0;
        stall_pct = 0;
        issue(pib_pkg::ACC_READ, pib_pkg::FN_IDE, 8'h03, 8'h00);
        issue(pib_pkg::ACC_READ, pib_pkg::FN_BRIDGE, 8'h03, 8'h00);
        issue(pib_pkg::ACC_WRITE, pib_pkg::FN_IDE, pib_pkg::IDE_STATUS, 8'hff);
        issue(pib_pkg::ACC_WRITE, pib_pkg::FN_IDE, IDE_CHAN_EN, 8'h40);
        issue(pib_pkg::ACC_WRITE, pib_pkg::FN_IDE, pib_pkg::IDE_CMD, 8'h00);
        issue(pib_pkg::ACC_WRITE, pib_pkg::FN_IDE, pib_pkg::IDE_CMD, 8'h01);
        issue(pib_pkg::ACC_WRITE, pib_pkg::FN_IDE, 8'h10, 8'h00);
        issue(pib_pkg::ACC_READ, 3'd2, 8'h00, 8'h00);
        random_run(250, 0, 0);

        // Both straps at zero
        write_strap(pib_pkg::CFG_BRIDGE_ID, 16'h0000);
        write_strap(pib_pkg::CFG_IDE_ID, 16'h0000);
        random_run(150, 60, 60);

        // IDE identity loaded but function 1 hidden
        write_strap(pib_pkg::CFG_BRIDGE_ID, 16'($urandom_range(16'hffff, 0)));
        write_strap(pib_pkg::CFG_IDE_ID, 16'($urandom_range(16'h6739, 1)));
        random_run(150, 20, 40);
        write_strap(pib_pkg::CFG_IDE_ID, 16'hffff);
        random_run(150, 40, 10);

        write_strap(pib_pkg::CFG_BRIDGE_ID, 16'($urandom_range(16'hffff, 0)));
        write_strap(pib_pkg::CFG_IDE_ID, pib_pkg::IDE_FULL_ID);
        random_run(350, 25, 25);

        if (board.expected_status.size() != 0)
        begin
            $error("%0d statuses never returned", board.expected_status.size());
            board.mismatches++;
        end
        if (board.mismatches == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end

    // Run limit
    initial
    begin
        #20_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule
